@@ rtl/cfb_pkg.sv @@
// Package: item types, command codes, frame constants and the CRC-16 byte update.
`default_nettype none
package cfb_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;

  localparam logic [2:0] IDX_SYNC0 = 3'd0;
  localparam logic [2:0] IDX_SYNC1 = 3'd1;
  localparam logic [2:0] IDX_FUNC  = 3'd2;
  localparam logic [2:0] IDX_LENHI = 3'd3;
  localparam logic [2:0] IDX_LENLO = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  func_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
  } tx_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cfb_seq.sv @@
// Item holding register and byte sequencer with running CRC and frame state.
`default_nettype none
module cfb_seq
  import cfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_item_t cmd_item,
  input  wire logic      res_ready,
  output logic           res_step,
  output tx_item_t       res_item
);

  logic        busy;
  cmd_item_t   item;
  logic [2:0]  idx;
  logic [15:0] crc;
  logic        in_frame;

  logic        busy_next;
  logic [2:0]  idx_next;
  logic [15:0] crc_next;
  logic        in_frame_next;

  logic        last;
  logic        covered;
  logic        load;
  logic        has_result;

  always_comb begin
    res_item = '0;
    last     = 1'b0;
    covered  = 1'b0;
    unique case (item.cmd)
      CMD_START: begin
        covered = 1'b1;
        case (idx)
          IDX_SYNC0: res_item.out_byte = SYNC_FIRST;
          IDX_SYNC1: res_item.out_byte = SYNC_SECOND;
          IDX_FUNC:  res_item.out_byte = item.func_code;
          IDX_LENHI: res_item.out_byte = item.payload_length[15:8];
          default: begin
            res_item.out_byte = item.payload_length[7:0];
            last = 1'b1;
          end
        endcase
      end
      CMD_DATA: begin
        covered           = 1'b1;
        res_item.out_byte = item.data_byte;
        last              = 1'b1;
      end
      CMD_END: begin
        if (idx == IDX_SYNC0) begin
          res_item.out_byte = crc[15:8];
        end else begin
          res_item.out_byte  = crc[7:0];
          res_item.frame_end = 1'b1;
          last               = 1'b1;
        end
      end
      default: last = 1'b1;
    endcase
    res_item.run_end = last;
  end

  assign res_step   = busy && res_ready;
  assign cmd_stall  = busy && !(res_step && last);
  assign load       = cmd_valid && !cmd_stall;
  assign has_result = (cmd_item.cmd == CMD_START) ||
                      (((cmd_item.cmd == CMD_DATA) || (cmd_item.cmd == CMD_END)) && in_frame);

  always_comb begin
    busy_next     = busy;
    idx_next      = idx;
    crc_next      = crc;
    in_frame_next = in_frame;
    if (res_step) begin
      if (last) begin
        busy_next = 1'b0;
      end
      idx_next = idx + 3'd1;
      if ((item.cmd == CMD_END) && last) begin
        crc_next = CRC_INIT;
      end else if (covered) begin
        crc_next = crc16_byte(crc, res_item.out_byte);
      end
    end
    if (load && has_result) begin
      busy_next = 1'b1;
      idx_next  = IDX_SYNC0;
      if (cmd_item.cmd == CMD_START) begin
        crc_next      = CRC_INIT;
        in_frame_next = 1'b1;
      end else if (cmd_item.cmd == CMD_END) begin
        in_frame_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= IDX_SYNC0;
      crc      <= CRC_INIT;
      in_frame <= 1'b0;
    end else begin
      busy     <= busy_next;
      idx      <= idx_next;
      crc      <= crc_next;
      in_frame <= in_frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && has_result) begin
      item <= cmd_item;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= IDX_LENLO))
    else $error("sequencer index out of range");

  a_end_clears_crc: assert property (@(posedge clk) disable iff (rst)
    (res_step && last && (item.cmd == CMD_END)) |=> (crc == CRC_INIT))
    else $error("crc not reinitialized after frame end");

  a_mid_item_busy: assert property (@(posedge clk) disable iff (rst)
    (res_step && !last) |=> busy)
    else $error("item dropped before its last byte");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (busy && !res_step) |=> ($stable(item) && $stable(idx)))
    else $error("item changed while waiting for output");

endmodule
`default_nettype wire

@@ rtl/cfb_out_reg.sv @@
// Output register for frame bytes on the valid/stall channel.
`default_nettype none
module cfb_out_reg
  import cfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_step,
  input  wire tx_item_t res_item,
  output logic          res_ready,
  output logic          tx_valid,
  input  wire logic     tx_stall,
  output tx_item_t      tx_item
);

  logic tx_valid_next;

  assign res_ready     = !tx_valid || !tx_stall;
  assign tx_valid_next = res_step || (tx_valid && tx_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else begin
      tx_valid <= tx_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_step) begin
      tx_item <= res_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crc16_frame_builder_unit.sv @@
// Top level of the CRC-16 frame builder.
//
//  channel   | direction | payload     | handshake
//  cmd_item  | in        | cmd_item_t  | cmd_valid / cmd_stall
//  tx_item   | out       | tx_item_t   | tx_valid / tx_stall
//
// One frame byte leaves the output register per cycle while tx is not stalled;
// the byte sequencer gives a start item 5 bytes, a payload item 1, an end item
// 2; items that give none do not occupy it. The next item is taken in the cycle
// its predecessor emits its last byte. Reset clears frame state and CRC.
// A stall on tx holds the output byte and, once the sequencer waits, cmd_stall.
`default_nettype none
module crc16_frame_builder_unit
  import cfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_item_t cmd_item,
  output logic           tx_valid,
  input  wire logic      tx_stall,
  output tx_item_t       tx_item
);

  logic     res_ready;
  logic     res_step;
  tx_item_t res_item;

  cfb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_ready (res_ready),
    .res_step  (res_step),
    .res_item  (res_item)
  );

  cfb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_step  (res_step),
    .res_item  (res_item),
    .res_ready (res_ready),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx_item   (tx_item)
  );

endmodule
`default_nettype wire

@@ tb/tb_crc16_frame_builder_unit.sv @@
// Self-checking testbench for the CRC-16 frame builder: directed and random item streams.
module tb_crc16_frame_builder_unit
  import cfb_pkg::*;
();

  localparam int CLK_HALF = 6;
  localparam int CLK_PERIOD = 2 * CLK_HALF;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PRINT_CAP = 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd_item;
  logic      tx_valid;
  logic      tx_stall;
  tx_item_t  tx_item;

  tx_item_t    frame_bytes_q[$];
  logic [15:0] crc_run;
  logic        frame_open;
  int          mismatches;
  int          caused_items;
  int          cmd_gap_max;
  int          tx_hold_max;

  crc16_frame_builder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx_item   (tx_item)
  );

  always #(CLK_HALF) clk = ~clk;

  // bit-serial reflected CRC, LSB of the byte first
  function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic cmd_item_t pack_item(input logic [1:0] cmd, input logic [7:0] fc,
                                          input logic [15:0] len, input logic [7:0] db);
    cmd_item_t it;
    it.cmd = cmd;
    it.func_code = fc;
    it.payload_length = len;
    it.data_byte = db;
    return it;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input logic fend,
                           input logic add_crc);
    tx_item_t t;
    t.out_byte = b;
    t.run_end = last;
    t.frame_end = fend;
    frame_bytes_q.push_back(t);
    if (add_crc) crc_run = crc_after(crc_run, b);
  endtask

  task automatic predict_frame_bytes(input cmd_item_t it);
    logic [15:0] c;
    case (it.cmd)
      CMD_START: begin
        crc_run = CRC_INIT;
        frame_open = 1'b1;
        push_byte(SYNC_FIRST, 1'b0, 1'b0, 1'b1);
        push_byte(SYNC_SECOND, 1'b0, 1'b0, 1'b1);
        push_byte(it.func_code, 1'b0, 1'b0, 1'b1);
        push_byte(it.payload_length[15:8], 1'b0, 1'b0, 1'b1);
        push_byte(it.payload_length[7:0], 1'b1, 1'b0, 1'b1);
        caused_items++;
      end
      CMD_DATA: begin
        if (frame_open) begin
          push_byte(it.data_byte, 1'b1, 1'b0, 1'b1);
          caused_items++;
        end
      end
      CMD_END: begin
        if (frame_open) begin
          c = crc_run;
          push_byte(c[15:8], 1'b0, 1'b0, 1'b0);
          push_byte(c[7:0], 1'b1, 1'b1, 1'b0);
          frame_open = 1'b0;
          crc_run = CRC_INIT;
          caused_items++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_tx_item(input tx_item_t got);
    tx_item_t want;
    if (frame_bytes_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h run_end %0b frame_end %0b",
                              got.out_byte, got.run_end, got.frame_end));
      return;
    end
    want = frame_bytes_q.pop_front();
    if (got.out_byte !== want.out_byte)
      flag_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.run_end !== want.run_end)
      flag_mismatch($sformatf("run_end %0b, want %0b (byte %02h)", got.run_end, want.run_end,
                              want.out_byte));
    if (got.frame_end !== want.frame_end)
      flag_mismatch($sformatf("frame_end %0b, want %0b (byte %02h)", got.frame_end,
                              want.frame_end, want.out_byte));
  endtask

  // valid stays high across back-to-back items; lowered only before a gap
  task automatic send_item(input cmd_item_t it);
    int gap;
    gap = $urandom_range(0, cmd_gap_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (cmd_stall);
    predict_frame_bytes(it);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // tx side: one stall draw per accepted byte
  initial begin
    int hold;
    tx_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx_valid && !tx_stall) begin
        check_tx_item(tx_item);
        hold = $urandom_range(0, tx_hold_max);
        if (hold > 0) begin
          tx_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          tx_stall <= 1'b0;
        end
      end
    end
  end

  task automatic test_outside_frame();
    cmd_gap_max = 12;
    tx_hold_max = 12;
    send_item(pack_item(CMD_DATA, 8'hFF, 16'hFFFF, 8'hFF));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    send_item(pack_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF));
    wait_drained();
  endtask

  task automatic test_header_extremes();
    send_item(pack_item(CMD_START, 8'h00, 16'h0000, 8'hFF));
    send_item(pack_item(CMD_DATA, 8'hFF, 16'hFFFF, 8'h00));
    send_item(pack_item(CMD_DATA, 8'h00, 16'h0000, 8'hFF));
    send_item(pack_item(CMD_END, 8'hFF, 16'hFFFF, 8'hFF));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    send_item(pack_item(CMD_START, 8'hFF, 16'hFFFF, 8'h00));
    send_item(pack_item(CMD_UNUSED, 8'h00, 16'h0000, 8'h00));
    send_item(pack_item(CMD_DATA, 8'h00, 16'h0000, 8'hA5));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    wait_drained();
  endtask

  task automatic test_restart_in_frame();
    send_item(pack_item(CMD_START, 8'h11, 16'h0203, 8'h00));
    send_item(pack_item(CMD_DATA, 8'h00, 16'h0000, 8'h3C));
    send_item(pack_item(CMD_START, 8'h5A, 16'h1234, 8'hFF));
    send_item(pack_item(CMD_DATA, 8'h00, 16'h0000, 8'hC3));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    wait_drained();
  endtask

  task automatic test_empty_frame();
    cmd_gap_max = 0;
    tx_hold_max = 0;
    send_item(pack_item(CMD_START, 8'h12, 16'h0001, 8'h00));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    send_item(pack_item(CMD_START, 8'h80, 16'h8000, 8'h00));
    send_item(pack_item(CMD_END, 8'h00, 16'h0000, 8'h00));
    wait_drained();
  endtask

  task automatic send_random_frame();
    int n;
    logic [15:0] len;
    len = 16'($urandom);
    case ($urandom_range(0, 7))
      0: len = 16'h0000;
      1: len = 16'hFFFF;
      default: ;
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    send_item(pack_item(CMD_START, 8'($urandom), len, 8'($urandom)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_item(pack_item(CMD_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom)));
      send_item(pack_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'($urandom)));
    end
    // sometimes leave the frame open so the next start restarts it
    if ($urandom_range(0, 9) != 0) begin
      send_item(pack_item(CMD_END, 8'($urandom), 16'($urandom), 8'($urandom)));
      if ($urandom_range(0, 9) == 0)
        send_item(pack_item($urandom_range(0, 1) ? CMD_DATA : CMD_END,
                            8'($urandom), 16'($urandom), 8'($urandom)));
    end
  endtask

  task automatic run_random_frames(input int target, input int gap_max, input int hold_max);
    int base;
    cmd_gap_max = gap_max;
    tx_hold_max = hold_max;
    base = caused_items;
    while (caused_items - base < target) send_random_frame();
    wait_drained();
  endtask

  task automatic test_random_frames();
    run_random_frames(190, 12, 12);
  endtask

  task automatic test_back_to_back();
    run_random_frames(85, 0, 0);
  endtask

  task automatic test_tx_backpressure();
    run_random_frames(85, 0, 12);
  endtask

  task automatic test_random_noise();
    int base;
    cmd_gap_max = 12;
    tx_hold_max = 0;
    base = caused_items;
    while (caused_items - base < 40) begin
      case ($urandom_range(0, 9))
        0, 1:    send_item(pack_item(CMD_START, 8'($urandom), 16'($urandom), 8'($urandom)));
        2, 3:    send_item(pack_item(CMD_END, 8'($urandom), 16'($urandom), 8'($urandom)));
        4:       send_item(pack_item(CMD_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom)));
        default: send_item(pack_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'($urandom)));
      endcase
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    crc_run = CRC_INIT;
    frame_open = 1'b0;
    mismatches = 0;
    caused_items = 0;
    cmd_gap_max = 0;
    tx_hold_max = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_outside_frame();
    test_header_extremes();
    test_restart_in_frame();
    test_empty_frame();
    test_random_frames();
    test_back_to_back();
    test_tx_backpressure();
    test_random_noise();
    if (mismatches == 0) begin
      $display("PASS crc16_frame_builder_unit");
    end else begin
      $display("FAIL crc16_frame_builder_unit");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL crc16_frame_builder_unit");
    $finish;
  end

endmodule
